// File: rtl/rscm_pkg.sv
// Shared types, widths and codes for the raster/screen coordinate mapper.
// No dependencies; used by every module of the mapper.
`timescale 1ns / 1ps

package rscm_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int MAX_SCALE = 64;
   localparam int OUT_WIDTH = 24;
   localparam int SCREEN_WIDTH = 9;
   localparam int SCALE_WIDTH = 8;

   localparam int SCALE_MAG_LIMIT =
      (MAX_SCALE < (1 << (SCALE_WIDTH - 1))) ? MAX_SCALE : (1 << (SCALE_WIDTH - 1));
   localparam int MAG_WIDTH = $clog2(SCALE_MAG_LIMIT + 1);
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + MAG_WIDTH + 1;
   localparam int SUM_WIDTH = PROD_WIDTH + 1;

   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_STAGES = (DIFF_WIDTH + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
   localparam int NUM_WIDTH = DIV_STAGES * DIV_RADIX_BITS;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RASTER_ORIGIN_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RASTER_ORIGIN_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SCREEN_ORIGIN_X = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SCREEN_ORIGIN_Y = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SCALE_FACTOR = 3'd4;

   localparam logic OP_RASTER_TO_SCREEN = 1'b0;
   localparam logic OP_SCREEN_TO_RASTER = 1'b1;

   typedef struct packed {
      logic                          op;
      logic signed [COORD_WIDTH-1:0] in_x;
      logic signed [COORD_WIDTH-1:0] in_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] out_x;
      logic signed [OUT_WIDTH-1:0] out_y;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] raster_origin_x;
      logic signed [COORD_WIDTH-1:0] raster_origin_y;
      logic [SCREEN_WIDTH-1:0]       screen_origin_x;
      logic [SCREEN_WIDTH-1:0]       screen_origin_y;
      logic signed [SCALE_WIDTH-1:0] scale_factor;
   } cfg_type;

   typedef struct packed {
      logic                         use_div;
      logic [MAG_WIDTH-1:0]         mag;
      logic signed [DIFF_WIDTH-1:0] diff_x;
      logic signed [DIFF_WIDTH-1:0] diff_y;
      logic signed [DIFF_WIDTH-1:0] add_x;
      logic signed [DIFF_WIDTH-1:0] add_y;
   } work_type;

endpackage

// File: rtl/rscm_front.sv
// Front end: accepts a coordinate word, decodes scale mode and clamps the magnitude,
// forms origin offsets and centring terms. Depends on rscm_pkg.
`timescale 1ns / 1ps

module rscm_front (
   input  logic               start,
   input  logic               busy,
   input  rscm_pkg::req_type  req_data,
   input  rscm_pkg::cfg_type  cfg,
   output logic               push,
   output rscm_pkg::work_type work
);

   localparam int MAG_W = rscm_pkg::MAG_WIDTH;
   localparam int DIFF_W = rscm_pkg::DIFF_WIDTH;
   localparam int SC_W = rscm_pkg::SCALE_WIDTH;
   localparam logic [SC_W:0] LIMIT = (SC_W + 1)'(rscm_pkg::SCALE_MAG_LIMIT);

   logic                     zoom;
   logic [SC_W:0]            sc_abs;
   logic [MAG_W-1:0]         mag;
   logic signed [DIFF_W-1:0] ix;
   logic signed [DIFF_W-1:0] iy;
   logic signed [DIFF_W-1:0] rox;
   logic signed [DIFF_W-1:0] roy;
   logic signed [DIFF_W-1:0] sox;
   logic signed [DIFF_W-1:0] soy;
   logic signed [DIFF_W-1:0] half_mag;
   logic signed [DIFF_W-1:0] half_block;

   assign push = start && !busy;

   always_comb begin
      zoom = cfg.scale_factor[SC_W-1];
      sc_abs = zoom ? -{cfg.scale_factor[SC_W-1], cfg.scale_factor}
                    : {1'b0, cfg.scale_factor};
      if (sc_abs == '0) begin
         mag = MAG_W'(1);
      end else if (sc_abs > LIMIT) begin
         mag = MAG_W'(LIMIT);
      end else begin
         mag = MAG_W'(sc_abs);
      end

      ix = DIFF_W'(req_data.in_x);
      iy = DIFF_W'(req_data.in_y);
      rox = DIFF_W'(cfg.raster_origin_x);
      roy = DIFF_W'(cfg.raster_origin_y);
      sox = $signed(DIFF_W'(cfg.screen_origin_x));
      soy = $signed(DIFF_W'(cfg.screen_origin_y));
      half_mag = $signed(DIFF_W'(mag >> 1));
      half_block = $signed(DIFF_W'((mag - MAG_W'(1)) >> 1));

      work.mag = mag;
      if (req_data.op == rscm_pkg::OP_RASTER_TO_SCREEN) begin
         work.use_div = !zoom;
         work.diff_x = ix - rox;
         work.diff_y = iy - roy;
         work.add_x = zoom ? sox + half_mag : sox;
         work.add_y = zoom ? soy + half_mag : soy;
      end else begin
         work.use_div = zoom;
         work.diff_x = ix - sox;
         work.diff_y = iy - soy;
         work.add_x = zoom ? rox : rox + half_block;
         work.add_y = zoom ? roy : roy + half_block;
      end
   end

endmodule

// File: rtl/rscm_queue.sv
// Short FIFO between front end and back end of the mapper.
// Drains one word per cycle whenever not empty. Depends on rscm_pkg.
`timescale 1ns / 1ps

module rscm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rscm_pkg::work_type push_data,
   output logic               full,
   output logic               pop_valid,
   output rscm_pkg::work_type pop_data
);

   localparam int DEPTH = rscm_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rscm_pkg::work_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_valid ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop_valid);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(DEPTH)) |-> !push)
      else $error("queue written while full");
`endif

endmodule

// File: rtl/rscm_back.sv
// Back end: multiplier and pipelined radix-4 restoring divider for both axes,
// final add of the origin and centring terms, result register. Depends on rscm_pkg.
`timescale 1ns / 1ps

module rscm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   input  rscm_pkg::work_type work,
   output logic               rsp_strobe,
   output rscm_pkg::rsp_type  rsp_data
);

   localparam int MAG_W = rscm_pkg::MAG_WIDTH;
   localparam int DIFF_W = rscm_pkg::DIFF_WIDTH;
   localparam int PROD_W = rscm_pkg::PROD_WIDTH;
   localparam int SUM_W = rscm_pkg::SUM_WIDTH;
   localparam int NUM_W = rscm_pkg::NUM_WIDTH;
   localparam int OUT_W = rscm_pkg::OUT_WIDTH;
   localparam int STAGES = rscm_pkg::DIV_STAGES;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [NUM_W-1:0] num;
   } div_state_type;

   typedef struct packed {
      logic                         valid;
      logic                         use_div;
      logic [MAG_W-1:0]             mag;
      logic                         neg_x;
      logic                         neg_y;
      div_state_type                div_x;
      div_state_type                div_y;
      logic signed [PROD_W-1:0]     prod_x;
      logic signed [PROD_W-1:0]     prod_y;
      logic signed [DIFF_W-1:0]     add_x;
      logic signed [DIFF_W-1:0]     add_y;
   } pipe_type;

   function automatic div_state_type div_step(input div_state_type s,
                                              input logic [MAG_W-1:0] d);
      div_state_type  r;
      logic [MAG_W:0] trial;
      r = s;
      for (int i = 0; i < rscm_pkg::DIV_RADIX_BITS; i++) begin
         trial = {r.rem, r.num[NUM_W-1]};
         r.num = {r.num[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, d}) begin
            r.rem = MAG_W'(trial - {1'b0, d});
            r.num[0] = 1'b1;
         end else begin
            r.rem = trial[MAG_W-1:0];
         end
      end
      return r;
   endfunction

   pipe_type                 pipe_ff [STAGES+1];
   pipe_type                 pipe_in [STAGES+1];
   logic                     rsp_strobe_ff;
   logic                     rsp_strobe_in;
   rscm_pkg::rsp_type        rsp_data_ff;
   rscm_pkg::rsp_type        rsp_data_in;
   logic [DIFF_W-1:0]        abs_x;
   logic [DIFF_W-1:0]        abs_y;
   logic signed [PROD_W-1:0] mag_s;
   logic signed [SUM_W-1:0]  q_x;
   logic signed [SUM_W-1:0]  q_y;
   logic signed [SUM_W-1:0]  sum_x;
   logic signed [SUM_W-1:0]  sum_y;

   always_comb begin
      abs_x = work.diff_x[DIFF_W-1] ? DIFF_W'(-work.diff_x) : DIFF_W'(work.diff_x);
      abs_y = work.diff_y[DIFF_W-1] ? DIFF_W'(-work.diff_y) : DIFF_W'(work.diff_y);
      mag_s = $signed(PROD_W'(work.mag));

      pipe_in[0].valid = work_valid;
      pipe_in[0].use_div = work.use_div;
      pipe_in[0].mag = work.mag;
      pipe_in[0].neg_x = work.diff_x[DIFF_W-1];
      pipe_in[0].neg_y = work.diff_y[DIFF_W-1];
      pipe_in[0].div_x.rem = '0;
      pipe_in[0].div_x.num = NUM_W'(abs_x);
      pipe_in[0].div_y.rem = '0;
      pipe_in[0].div_y.num = NUM_W'(abs_y);
      pipe_in[0].prod_x = PROD_W'(work.diff_x) * mag_s;
      pipe_in[0].prod_y = PROD_W'(work.diff_y) * mag_s;
      pipe_in[0].add_x = work.add_x;
      pipe_in[0].add_y = work.add_y;

      for (int k = 1; k <= STAGES; k++) begin
         pipe_in[k] = pipe_ff[k-1];
         pipe_in[k].div_x = div_step(pipe_ff[k-1].div_x, pipe_ff[k-1].mag);
         pipe_in[k].div_y = div_step(pipe_ff[k-1].div_y, pipe_ff[k-1].mag);
      end

      q_x = $signed(SUM_W'(pipe_ff[STAGES].div_x.num[DIFF_W-1:0]));
      q_y = $signed(SUM_W'(pipe_ff[STAGES].div_y.num[DIFF_W-1:0]));
      if (pipe_ff[STAGES].neg_x) begin
         q_x = -q_x;
      end
      if (pipe_ff[STAGES].neg_y) begin
         q_y = -q_y;
      end
      sum_x = (pipe_ff[STAGES].use_div ? q_x : SUM_W'(pipe_ff[STAGES].prod_x))
            + SUM_W'(pipe_ff[STAGES].add_x);
      sum_y = (pipe_ff[STAGES].use_div ? q_y : SUM_W'(pipe_ff[STAGES].prod_y))
            + SUM_W'(pipe_ff[STAGES].add_y);

      rsp_strobe_in = pipe_ff[STAGES].valid;
      rsp_data_in.out_x = sum_x[OUT_W-1:0];
      rsp_data_in.out_y = sum_y[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STAGES; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
         rsp_strobe_ff <= 1'b0;
      end else begin
         for (int k = 0; k <= STAGES; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_strobe_follows_pipe: assert property (@(posedge clock) disable iff (reset)
      pipe_ff[STAGES].valid |=> rsp_strobe_ff)
      else $error("finished word not presented");

   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      pipe_ff[STAGES].valid |->
         (pipe_ff[STAGES].div_x.rem < pipe_ff[STAGES].mag) &&
         (pipe_ff[STAGES].div_y.rem < pipe_ff[STAGES].mag))
      else $error("divider remainder not below divisor");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      pipe_ff[0].valid |-> (pipe_ff[0].mag != '0))
      else $error("zero scale magnitude entered back end");
`endif

endmodule

// File: rtl/raster_screen_coordinate_mapper_core.sv
// Raster/screen coordinate mapper. One coordinate word is taken per clock while busy is
// low; busy rises only if the two-entry queue between front end and back end is full,
// which does not happen since the back end drains a word every cycle. Each result
// appears on rsp_data with rsp_strobe for one cycle, after passing through the queue,
// the pipelined radix-4 divider (nine stages for a 17-bit offset) and the result
// register. Results keep input order and cannot be held off.
`timescale 1ns / 1ps

module raster_screen_coordinate_mapper_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  rscm_pkg::req_type                     req_data,
   output logic                                  rsp_strobe,
   output rscm_pkg::rsp_type                     rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rscm_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [rscm_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [rscm_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                  pready
);

   localparam int DW = rscm_pkg::CSR_DATA_WIDTH;

   rscm_pkg::cfg_type                    cfg_ff;
   rscm_pkg::cfg_type                    cfg_in;
   logic [rscm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic                                 csr_write;
   logic                                 push;
   rscm_pkg::work_type                   push_data;
   logic                                 pop_valid;
   rscm_pkg::work_type                   pop_data;

   assign pready = 1'b1;
   assign csr_index = paddr[rscm_pkg::CSR_ADDR_WIDTH-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            rscm_pkg::REG_RASTER_ORIGIN_X:
               cfg_in.raster_origin_x = pwdata[rscm_pkg::COORD_WIDTH-1:0];
            rscm_pkg::REG_RASTER_ORIGIN_Y:
               cfg_in.raster_origin_y = pwdata[rscm_pkg::COORD_WIDTH-1:0];
            rscm_pkg::REG_SCREEN_ORIGIN_X:
               cfg_in.screen_origin_x = pwdata[rscm_pkg::SCREEN_WIDTH-1:0];
            rscm_pkg::REG_SCREEN_ORIGIN_Y:
               cfg_in.screen_origin_y = pwdata[rscm_pkg::SCREEN_WIDTH-1:0];
            rscm_pkg::REG_SCALE_FACTOR:
               cfg_in.scale_factor = pwdata[rscm_pkg::SCALE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rscm_pkg::REG_RASTER_ORIGIN_X: prdata = DW'($unsigned(cfg_ff.raster_origin_x));
         rscm_pkg::REG_RASTER_ORIGIN_Y: prdata = DW'($unsigned(cfg_ff.raster_origin_y));
         rscm_pkg::REG_SCREEN_ORIGIN_X: prdata = DW'(cfg_ff.screen_origin_x);
         rscm_pkg::REG_SCREEN_ORIGIN_Y: prdata = DW'(cfg_ff.screen_origin_y);
         rscm_pkg::REG_SCALE_FACTOR:    prdata = DW'($unsigned(cfg_ff.scale_factor));
         default:                       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raster_origin_x <= '0;
         cfg_ff.raster_origin_y <= '0;
         cfg_ff.screen_origin_x <= '0;
         cfg_ff.screen_origin_y <= '0;
         cfg_ff.scale_factor <= rscm_pkg::SCALE_WIDTH'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rscm_front u_front (
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .push     (push),
      .work     (push_data)
   );

   rscm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (busy),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   rscm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (pop_valid),
      .work       (pop_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
